### hw/rtl/idc_pkg.sv
// ----------------------------------------------------------------------------
// idc_pkg
// Shared types and codes of the image depth converter: register indexes,
// conversion modes, configuration and packing state records, result jobs.
// ----------------------------------------------------------------------------
package idc_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_CONVERSION_MODE  = 2'd0;
    localparam logic [1:0] CFG_OVERFLOW_POLICY  = 2'd1;
    localparam logic [1:0] CFG_SHIFT_AMOUNT     = 2'd2;
    localparam logic [1:0] CFG_FIRST_BIT_OFFSET = 2'd3;

    // Conversion modes; codes above MODE_U32_TO_U1 mean nothing
    localparam logic [3:0] MODE_U8_TO_S16  = 4'd0;
    localparam logic [3:0] MODE_S16_TO_U8  = 4'd1;
    localparam logic [3:0] MODE_U1_TO_U8   = 4'd2;
    localparam logic [3:0] MODE_U1_TO_U16  = 4'd3;
    localparam logic [3:0] MODE_U1_TO_S16  = 4'd4;
    localparam logic [3:0] MODE_U1_TO_U32  = 4'd5;
    localparam logic [3:0] MODE_U8_TO_U1   = 4'd6;
    localparam logic [3:0] MODE_U16_TO_U1  = 4'd7;
    localparam logic [3:0] MODE_S16_TO_U1  = 4'd8;
    localparam logic [3:0] MODE_U32_TO_U1  = 4'd9;

    // Overflow policy for S16 to U8 narrowing
    localparam logic POLICY_WRAP     = 1'b0;
    localparam logic POLICY_SATURATE = 1'b1;

    localparam logic [7:0]  FULL_MASK = 8'hFF;
    localparam logic [3:0]  BYTE_BITS = 4'd8;
    localparam logic [7:0]  U8_MAX    = 8'd255;

    typedef struct packed {
        logic [3:0] conversion_mode;
        logic       overflow_policy;
        logic [3:0] shift_amount;
        logic [2:0] first_bit_offset;
    } t_cfg;

    typedef struct packed {
        logic [7:0] pack_byte;
        logic [7:0] pack_mask;
        logic [2:0] bit_position;
        logic       row_start;
    } t_pack_state;

    // One item's results: a single pixel/byte, or an expansion of packed bits
    typedef struct packed {
        logic        expand;
        logic [31:0] value;     // pixel value, or all-ones pattern when expanding
        logic [7:0]  mask;
        logic [7:0]  bits;      // packed bits, first taken bit at bit 0
        logic [3:0]  take;      // number of results, 1..8
    } t_job;

endpackage

### hw/rtl/idc_in_if.sv
// ----------------------------------------------------------------------------
// idc_in_if
// Pixel input channel: valid/ready handshake with one sample per transfer.
// ----------------------------------------------------------------------------
interface idc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample;
    logic [3:0]  pixel_count;
    logic        row_end;

    modport source (output valid, output sample, output pixel_count, output row_end,
                    input ready);
    modport sink   (input valid, input sample, input pixel_count, input row_end,
                    output ready);
endinterface

### hw/rtl/idc_out_if.sv
// ----------------------------------------------------------------------------
// idc_out_if
// Result output channel: valid/ready handshake with one result per transfer.
// ----------------------------------------------------------------------------
interface idc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_value;
    logic [7:0]  bit_mask;
    logic        last;

    modport source (output valid, output out_value, output bit_mask, output last,
                    input ready);
    modport sink   (input valid, input out_value, input bit_mask, input last,
                    output ready);
endinterface

### hw/rtl/idc_cfg_if.sv
// ----------------------------------------------------------------------------
// idc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface idc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [3:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/idc_item_decode.sv
// ----------------------------------------------------------------------------
// idc_item_decode
// Converts one input item against the current configuration and packing
// state: builds the result job and the packing state after the item.
// ----------------------------------------------------------------------------
module idc_item_decode
    import idc_pkg::*;
(
    input  t_cfg        i_cfg,
    input  t_pack_state i_state,
    input  logic [31:0] i_sample,
    input  logic [3:0]  i_pixel_count,
    input  logic        i_row_end,
    output t_job        o_job,
    output logic        o_has_result,
    output t_pack_state o_state_next
);

    logic        mode_defined;
    logic [15:0] widen_value;
    logic [15:0] narrow_shifted;
    logic [7:0]  narrow_value;
    logic [2:0]  unpack_start;
    logic [3:0]  count_capped;
    logic [3:0]  bits_left;
    logic [3:0]  unpack_take;
    logic [3:0]  unpack_end;
    logic [31:0] ones_value;
    logic        nonzero;
    logic [7:0]  base_byte;
    logic [7:0]  base_mask;
    logic [2:0]  pack_pos;
    logic [7:0]  pos_sel;
    logic [7:0]  packed_byte;
    logic [7:0]  packed_mask;

    assign mode_defined = (i_cfg.conversion_mode <= MODE_U32_TO_U1);

    // U8 to S16: shift left, keep 16 bits
    assign widen_value = 16'(i_sample[7:0]) << i_cfg.shift_amount;

    // S16 to U8: arithmetic right shift, then wrap or clamp
    assign narrow_shifted = 16'($signed(i_sample[15:0]) >>> i_cfg.shift_amount);

    always_comb begin
        priority if (i_cfg.overflow_policy == POLICY_SATURATE) begin
            if (narrow_shifted[15]) begin
                narrow_value = 8'd0;
            end else if (narrow_shifted[14:8] != 7'd0) begin
                narrow_value = U8_MAX;
            end else begin
                narrow_value = narrow_shifted[7:0];
            end
        end else begin
            narrow_value = narrow_shifted[7:0];
        end
    end

    // Packed U1 source: bit walk within the byte
    assign unpack_start = i_state.row_start ? i_cfg.first_bit_offset : i_state.bit_position;
    assign count_capped = (i_pixel_count > BYTE_BITS) ? BYTE_BITS : i_pixel_count;
    assign bits_left    = BYTE_BITS - {1'b0, unpack_start};
    assign unpack_take  = (count_capped > bits_left) ? bits_left : count_capped;
    assign unpack_end   = {1'b0, unpack_start} + unpack_take;

    always_comb begin
        unique case (i_cfg.conversion_mode)
            MODE_U1_TO_U8:  ones_value = 32'h0000_00FF;
            MODE_U1_TO_U32: ones_value = 32'hFFFF_FFFF;
            default:        ones_value = 32'h0000_FFFF;
        endcase
    end

    // U1 output: pixel test and bit insert
    always_comb begin
        unique case (i_cfg.conversion_mode)
            MODE_U8_TO_U1:  nonzero = (i_sample[7:0] != 8'd0);
            MODE_U32_TO_U1: nonzero = (i_sample != 32'd0);
            default:        nonzero = (i_sample[15:0] != 16'd0);
        endcase
    end

    assign base_byte   = i_state.row_start ? 8'd0 : i_state.pack_byte;
    assign base_mask   = i_state.row_start ? 8'd0 : i_state.pack_mask;
    assign pack_pos    = i_state.row_start ? i_cfg.first_bit_offset : i_state.bit_position;
    assign pos_sel     = 8'd1 << pack_pos;
    assign packed_byte = (base_byte & ~pos_sel) | (nonzero ? pos_sel : 8'd0);
    assign packed_mask = base_mask | pos_sel;

    // Select job and next state by mode
    always_comb begin
        o_job                  = '0;
        o_job.mask             = FULL_MASK;
        o_job.take             = 4'd1;
        o_has_result           = 1'b0;
        o_state_next           = i_state;
        o_state_next.row_start = mode_defined ? i_row_end : i_state.row_start;

        priority if (!mode_defined) begin
            o_has_result = 1'b0;
        end else if (i_cfg.conversion_mode == MODE_U8_TO_S16) begin
            o_has_result = 1'b1;
            o_job.value  = {16'd0, widen_value};
        end else if (i_cfg.conversion_mode == MODE_S16_TO_U8) begin
            o_has_result = 1'b1;
            o_job.value  = {24'd0, narrow_value};
        end else if (i_cfg.conversion_mode <= MODE_U1_TO_U32) begin
            o_has_result              = (unpack_take != 4'd0);
            o_job.expand              = 1'b1;
            o_job.value               = ones_value;
            o_job.bits                = i_sample[7:0] >> unpack_start;
            o_job.take                = unpack_take;
            o_state_next.bit_position = unpack_end[2:0];
        end else begin
            if (pack_pos == 3'd7 || i_row_end) begin
                o_has_result              = 1'b1;
                o_job.value               = {24'd0, packed_byte};
                o_job.mask                = packed_mask;
                o_state_next.pack_byte    = 8'd0;
                o_state_next.pack_mask    = 8'd0;
                o_state_next.bit_position = 3'd0;
            end else begin
                o_state_next.pack_byte    = packed_byte;
                o_state_next.pack_mask    = packed_mask;
                o_state_next.bit_position = pack_pos + 3'd1;
            end
        end
    end

endmodule

### hw/rtl/image_depth_converter.sv
// ----------------------------------------------------------------------------
// image_depth_converter
// Streams pixels between image depths: U8/S16 shifts, U1 unpacking into
// wide pixels and U1 packing into masked bytes, one row at a time.
//
//   channel   port     dir   per transfer
//   -------   ------   ---   ------------------------------------------
//   pixels    i_in     in    sample, pixel_count, row_end
//   results   o_out    out   out_value, bit_mask, last
//   config    i_cfg    in    index (0..3), data; always ready
//
// An item enters a job register in the cycle it is accepted; its results
// pass from there to the output register. While the output does not stall,
// ordinary pixels run at one item per cycle and a packed U1 source byte
// yields up to 8 results, one per cycle; the next item is taken as its last
// result leaves the job register. Output stalls hold the output register
// and back up into i_in.ready. Synchronous active-low reset clears config,
// packing state and valid flags; a row starts right after reset.
// ----------------------------------------------------------------------------
module image_depth_converter
    import idc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    idc_in_if.sink    i_in,
    idc_out_if.source o_out,
    idc_cfg_if.sink   i_cfg
);

    t_cfg        r_cfg;
    t_pack_state r_state;
    t_pack_state n_state;
    t_job        r_job;
    t_job        n_job;
    logic        r_job_valid;
    logic [2:0]  r_idx;
    logic        r_out_valid;
    logic [31:0] r_out_value;
    logic [7:0]  r_out_mask;
    logic        r_out_last;

    logic        has_result;
    logic        in_xfer;
    logic        out_load;
    logic        elem_last;
    logic        job_done;
    logic [31:0] elem_value;

    // Configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_CONVERSION_MODE:  r_cfg.conversion_mode  <= i_cfg.data;
                CFG_OVERFLOW_POLICY:  r_cfg.overflow_policy  <= i_cfg.data[0];
                CFG_SHIFT_AMOUNT:     r_cfg.shift_amount     <= i_cfg.data;
                CFG_FIRST_BIT_OFFSET: r_cfg.first_bit_offset <= i_cfg.data[2:0];
                default:              r_cfg <= r_cfg;
            endcase
        end
    end

    // Item conversion
    idc_item_decode u_decode (
        .i_cfg         (r_cfg),
        .i_state       (r_state),
        .i_sample      (i_in.sample),
        .i_pixel_count (i_in.pixel_count),
        .i_row_end     (i_in.row_end),
        .o_job         (n_job),
        .o_has_result  (has_result),
        .o_state_next  (n_state)
    );

    // Current element of the job
    assign elem_value = (r_job.expand && !r_job.bits[r_idx]) ? 32'd0 : r_job.value;
    assign elem_last  = ({1'b0, r_idx} == (r_job.take - 4'd1));
    assign out_load   = r_job_valid && (!r_out_valid || o_out.ready);
    assign job_done   = out_load && elem_last;

    assign i_in.ready = !r_job_valid || job_done;
    assign in_xfer    = i_in.valid && i_in.ready;

    // Packing state advances with every accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{pack_byte: 8'd0, pack_mask: 8'd0, bit_position: 3'd0,
                         row_start: 1'b1};
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    // Job register: load on transfer, step one result at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= 3'd0;
        end else if (in_xfer) begin
            r_job_valid <= has_result;
            r_idx       <= 3'd0;
        end else if (job_done) begin
            r_job_valid <= 1'b0;
        end else if (out_load) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_job <= n_job;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value <= elem_value;
            r_out_mask  <= r_job.expand ? FULL_MASK : r_job.mask;
            r_out_last  <= elem_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_value = r_out_value;
    assign o_out.bit_mask  = r_out_mask;
    assign o_out.last      = r_out_last;

endmodule

### sim/tb_image_depth_converter.sv
// ----------------------------------------------------------------------------
// tb_image_depth_converter
// Self-checking bench for the image depth converter. A scoreboard class
// predicts every result from the accepted pixel items and the register
// settings, and compares each result transfer field by field. A directed
// pass covers shift and clamp extremes, bit walk offsets, count cuts and
// packed-byte flushes; random phases then vary the settings, the idle and
// stall pressure on both channels, and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_image_depth_converter;
    import idc_pkg::*;

    localparam int SETTLE_CYCLES   = 16;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int NUM_PHASES      = 25;
    localparam int ITEMS_PER_PHASE = 21;
    localparam int HOLD_PHASE      = 4;
    localparam int IGNORED_PHASE   = 13;
    localparam int HOLD_CYCLES     = 200;

    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  mask;
        logic        last;
    } conv_result_t;

    // Tracks the converter's registers and packing state, and holds the
    // results still owed by the block in order.
    class conversion_scoreboard;
        logic [3:0]   cfg_mode;
        logic         cfg_policy;
        logic [3:0]   cfg_shift;
        logic [2:0]   cfg_offset;
        logic [7:0]   pack_byte;
        logic [7:0]   pack_mask;
        logic [2:0]   bit_pos;
        logic         row_start;
        conv_result_t expected_pixels[$];
        int unsigned  errors;

        function new();
            cfg_mode   = MODE_U8_TO_S16;
            cfg_policy = POLICY_WRAP;
            cfg_shift  = '0;
            cfg_offset = '0;
            pack_byte  = '0;
            pack_mask  = '0;
            bit_pos    = '0;
            row_start  = 1'b1;
            errors     = 0;
        endfunction

        function void write_register(logic [1:0] index, logic [3:0] data);
            case (index)
                CFG_CONVERSION_MODE:  cfg_mode = data;
                CFG_OVERFLOW_POLICY:  cfg_policy = data[0];
                CFG_SHIFT_AMOUNT:     cfg_shift = data;
                CFG_FIRST_BIT_OFFSET: cfg_offset = data[2:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // Arithmetic right shift of a signed 16-bit pixel, then wrap or clamp
        function logic [7:0] narrow_pixel(logic [31:0] raw);
            logic signed [15:0] v;
            logic signed [15:0] r;
            v = raw[15:0];
            r = v >>> cfg_shift;
            if (cfg_policy == POLICY_SATURATE) begin
                if (v[15]) return 8'd0;
                if (r > 16'sd255) return U8_MAX;
            end
            return r[7:0];
        endfunction

        // Work out the results of one accepted item and advance the state
        function void accept_item(logic [31:0] smp, logic [3:0] cnt, logic eor);
            logic [15:0] wide;
            logic [31:0] ones;
            logic [2:0]  pos;
            logic        nz;
            int          first;
            int          take;
            int          tmp;
            if (cfg_mode > MODE_U32_TO_U1) return;

            if (cfg_mode == MODE_U8_TO_S16) begin
                wide = {8'h00, smp[7:0]} << cfg_shift;
                expected_pixels.push_back('{{16'h0000, wide}, FULL_MASK, 1'b1});
            end else if (cfg_mode == MODE_S16_TO_U8) begin
                expected_pixels.push_back('{{24'h0, narrow_pixel(smp)}, FULL_MASK, 1'b1});
            end else if (cfg_mode <= MODE_U1_TO_U32) begin
                // expand packed bits, cut to what is left of the byte
                first = row_start ? int'(cfg_offset) : int'(bit_pos);
                take  = (cnt > BYTE_BITS) ? 8 : int'(cnt);
                if (take > 8 - first) take = 8 - first;
                case (cfg_mode)
                    MODE_U1_TO_U8:  ones = 32'h0000_00FF;
                    MODE_U1_TO_U32: ones = 32'hFFFF_FFFF;
                    default:        ones = 32'h0000_FFFF;
                endcase
                for (int i = 0; i < take; i++) begin
                    expected_pixels.push_back('{smp[(first + i) % 8] ? ones : 32'h0,
                                                FULL_MASK, (i == take - 1)});
                end
                tmp = first + take;
                bit_pos = tmp[2:0];
            end else begin
                // pack one bit; emit on bit 7 or at the row end
                case (cfg_mode)
                    MODE_U8_TO_U1:  nz = |smp[7:0];
                    MODE_U32_TO_U1: nz = |smp;
                    default:        nz = |smp[15:0];
                endcase
                if (row_start) begin
                    pack_byte = '0;
                    pack_mask = '0;
                    bit_pos   = cfg_offset;
                end
                pos = bit_pos;
                pack_byte[pos] = nz;
                pack_mask[pos] = 1'b1;
                if (pos == 3'd7 || eor) begin
                    expected_pixels.push_back('{{24'h0, pack_byte}, pack_mask, 1'b1});
                    pack_byte = '0;
                    pack_mask = '0;
                    bit_pos   = '0;
                end else begin
                    bit_pos = pos + 3'd1;
                end
            end
            row_start = eor;
        endfunction

        function void match_result(logic [31:0] value, logic [7:0] mask, logic last);
            conv_result_t want;
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result: out_value %h bit_mask %h last %b",
                         $time, value, mask, last);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            if (value !== want.value) begin
                $display("%0t: out_value expected %h actual %h", $time, want.value, value);
                errors++;
            end
            if (mask !== want.mask) begin
                $display("%0t: bit_mask expected %h actual %h", $time, want.mask, mask);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last expected %b actual %b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   stall_pct;
    logic hold_req;
    int   hold_left;
    int   cycle_count;

    conversion_scoreboard scoreboard = new();

    idc_in_if  in_ch();
    idc_out_if out_ch();
    idc_cfg_if cfg_ch();

    image_depth_converter DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // Free-running clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off counted here
    always @(negedge clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Check every result transfer
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            scoreboard.match_result(out_ch.out_value, out_ch.bit_mask, out_ch.last);
        end
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("image_depth_converter regression: fail");
            $finish;
        end
    end

    task automatic send_item(input logic [31:0] smp, input logic [3:0] cnt, input logic eor);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid       <= 1'b1;
        in_ch.sample      <= smp;
        in_ch.pixel_count <= cnt;
        in_ch.row_end     <= eor;
        do @(posedge clk); while (!in_ch.ready);
        scoreboard.accept_item(smp, cnt, eor);
    endtask

    // Drop valid, wait for every owed result, then let the pipe settle
    task automatic wait_for_drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [3:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        scoreboard.write_register(index, data);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic load_settings(input logic [3:0] mode, input logic policy,
                                 input logic [3:0] shift, input logic [2:0] offset);
        wait_for_drain();
        write_register(CFG_CONVERSION_MODE, mode);
        write_register(CFG_OVERFLOW_POLICY, {3'b000, policy});
        write_register(CFG_SHIFT_AMOUNT, shift);
        write_register(CFG_FIRST_BIT_OFFSET, {1'b0, offset});
    endtask

    // Shape a random item to the current mode
    task automatic send_random_item();
        logic [31:0] smp;
        logic [3:0]  cnt;
        logic        eor;
        int          pick;
        smp  = $urandom;
        cnt  = 4'($urandom_range(0, 15));
        eor  = ($urandom_range(0, 5) == 0);
        pick = $urandom_range(0, 3);
        if (scoreboard.cfg_mode == MODE_U8_TO_S16) begin
            if (pick == 0) smp[7:0] = 8'hFF;
        end else if (scoreboard.cfg_mode == MODE_S16_TO_U8) begin
            case (pick)
                0: smp[15:0] = 16'h7FFF;
                1: smp[15:0] = 16'h8000;
                2: smp[15:0] = 16'hFFFF;
                default: ;
            endcase
        end else if (scoreboard.cfg_mode <= MODE_U1_TO_U32) begin
            if (pick != 0) cnt = 4'($urandom_range(1, 8));
        end else if (scoreboard.cfg_mode <= MODE_U32_TO_U1) begin
            // zero pixels, pixels set only in bits 31:16 or only in bits 7:0, and longer rows
            case (pick)
                0: smp = '0;
                1: smp = smp & 32'hFFFF_0000;
                2: smp = smp & 32'h0000_00FF;
                default: ;
            endcase
            eor = ($urandom_range(0, 9) == 0);
        end
        send_item(smp, cnt, eor);
    endtask

    task automatic run_directed();
        load_settings(MODE_U8_TO_S16, POLICY_WRAP, 4'd0, 3'd0);
        send_item(32'hFFFF_FFFF, 4'hF, 1'b1);
        send_item(32'h0000_0000, 4'h0, 1'b0);
        load_settings(MODE_U8_TO_S16, POLICY_WRAP, 4'd15, 3'd0);
        send_item(32'h0000_00FF, 4'd8, 1'b0);
        send_item(32'h0000_0001, 4'd1, 1'b0);
        load_settings(MODE_S16_TO_U8, POLICY_WRAP, 4'd0, 3'd0);
        send_item(32'h0000_7FFF, 4'd1, 1'b0);
        send_item(32'h0000_8000, 4'd1, 1'b0);
        load_settings(MODE_S16_TO_U8, POLICY_SATURATE, 4'd4, 3'd0);
        send_item(32'h0000_7FFF, 4'd1, 1'b0);
        send_item(32'hFFFF_8000, 4'd1, 1'b0);
        send_item(32'h0000_0FF0, 4'd1, 1'b0);
        load_settings(MODE_S16_TO_U8, POLICY_SATURATE, 4'd15, 3'd0);
        send_item(32'h0000_FFFF, 4'd1, 1'b0);
        send_item(32'h0000_7FFF, 4'd1, 1'b0);
        // offset at the last bit cuts the count; a zero count still ends the row
        load_settings(MODE_U1_TO_U8, POLICY_WRAP, 4'd0, 3'd7);
        send_item(32'h0000_0080, 4'd8, 1'b0);
        send_item(32'h0000_00FF, 4'd0, 1'b1);
        send_item(32'h0000_00A5, 4'd15, 1'b0);
        send_item(32'h0000_005A, 4'd3, 1'b1);
        load_settings(MODE_U1_TO_U16, POLICY_WRAP, 4'd0, 3'd0);
        send_item(32'h0000_00A5, 4'd8, 1'b1);
        load_settings(MODE_U1_TO_S16, POLICY_WRAP, 4'd0, 3'd0);
        send_item(32'h0000_003C, 4'd8, 1'b1);
        load_settings(MODE_U1_TO_U32, POLICY_WRAP, 4'd0, 3'd3);
        send_item(32'h0000_00F0, 4'd5, 1'b1);
        // pack from bit 5, fill to bit 7, then flush a one-bit byte at row end
        load_settings(MODE_U8_TO_U1, POLICY_WRAP, 4'd0, 3'd5);
        send_item(32'h0000_0001, 4'd0, 1'b0);
        send_item(32'h0000_0100, 4'd0, 1'b0);
        send_item(32'h0000_00FF, 4'd0, 1'b0);
        send_item(32'h0000_0001, 4'd0, 1'b1);
        load_settings(MODE_U32_TO_U1, POLICY_WRAP, 4'd0, 3'd0);
        send_item(32'h8000_0000, 4'd0, 1'b1);
        // undefined mode: ignored
        load_settings(4'd15, POLICY_WRAP, 4'd0, 3'd0);
        send_item(32'h1234_5678, 4'd8, 1'b1);
    endtask

    task automatic run_random();
        logic [3:0] mode;
        logic [3:0] shift;
        logic [2:0] offset;
        logic       policy;
        int         n;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == IGNORED_PHASE) mode = 4'($urandom_range(10, 15));
            else if (ph == HOLD_PHASE) mode = MODE_U8_TO_S16;
            else mode = 4'($urandom_range(0, 9));
            case ($urandom_range(0, 3))
                0: shift = 4'd0;
                1: shift = 4'd15;
                default: shift = 4'($urandom_range(0, 15));
            endcase
            case ($urandom_range(0, 3))
                0: offset = 3'd0;
                1: offset = 3'd7;
                default: offset = 3'($urandom_range(0, 7));
            endcase
            policy = 1'($urandom_range(0, 1));
            load_settings(mode, policy, shift, offset);

            // rotate idle pressure: none, sender, receiver, both
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 65; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 65; end
                default: begin send_idle_pct = 37; stall_pct = 37; end
            endcase
            if (ph == HOLD_PHASE) hold_req = 1'b1;

            n = (ph == IGNORED_PHASE) ? 4 : ITEMS_PER_PHASE;
            repeat (n) send_random_item();
        end
    endtask

    initial begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        hold_req          = 1'b0;
        hold_left         = 0;
        cycle_count       = 0;
        in_ch.valid       = 1'b0;
        in_ch.sample      = '0;
        in_ch.pixel_count = '0;
        in_ch.row_end     = 1'b0;
        out_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random();
        wait_for_drain();

        if (scoreboard.errors == 0) begin
            $display("image_depth_converter regression: pass");
        end else begin
            $display("image_depth_converter regression: fail");
        end
        $finish;
    end

endmodule
